@@ rtl/stoi_pkg.sv @@
// Shared types, constants and helper functions for the string-to-integer converter.
package stoi_pkg;

    localparam int MAX_SYMBOLS = 16;
    localparam int SYM_IDX_W   = $clog2(MAX_SYMBOLS);
    localparam int LEN_W       = 5;
    localparam int ACC_W       = 32;
    localparam int SYM_REG_W   = 64;
    localparam int CFG_IDX_W   = 2;
    localparam int CQ_DEPTH    = 4;
    localparam int CQ_PTR_W    = $clog2(CQ_DEPTH);
    localparam int CQ_CNT_W    = $clog2(CQ_DEPTH + 1);
    localparam int OQ_DEPTH    = 2;
    localparam int OQ_PTR_W    = $clog2(OQ_DEPTH);
    localparam int OQ_CNT_W    = $clog2(OQ_DEPTH + 1);

    localparam logic [LEN_W-1:0] BASE_LENGTH_RESET = LEN_W'(10);

    localparam logic [7:0] CHAR_NUL   = 8'h00;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SYMBOLS_LOW  = 2'd0,
        CFG_SYMBOLS_HIGH = 2'd1,
        CFG_BASE_LENGTH  = 2'd2
    } t_cfg_index;

    typedef enum logic [1:0] {
        PH_SKIP   = 2'd0,
        PH_SIGNS  = 2'd1,
        PH_DIGITS = 2'd2,
        PH_DONE   = 2'd3
    } t_phase;

    typedef struct packed {
        logic [MAX_SYMBOLS-1:0][7:0] symbols;
        logic [LEN_W-1:0]            used_len;
        logic                        alphabet_ok;
    } t_cfg_view;

    typedef struct packed {
        logic                 last;
        logic                 is_space;
        logic                 is_plus;
        logic                 is_minus;
        logic                 is_digit;
        logic [SYM_IDX_W-1:0] digit;
    } t_class;

    function automatic logic is_space(input logic [7:0] c);
        return (c == CHAR_SPACE) || ((c >= CHAR_TAB) && (c <= CHAR_CR));
    endfunction

endpackage

@@ rtl/stoi_cfg.sv @@
// Configuration registers, used alphabet length and the alphabet validity check.
module stoi_cfg import stoi_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [SYM_REG_W-1:0] i_cfg_wdata,
    output t_cfg_view            o_cfg
);

    logic [SYM_REG_W-1:0]        r_symbols_low;
    logic [SYM_REG_W-1:0]        r_symbols_high;
    logic [LEN_W-1:0]            r_base_length;
    logic                        r_alphabet_ok;
    logic                        n_alphabet_ok;
    logic [LEN_W-1:0]            used_len;
    logic [2*SYM_REG_W-1:0]      all_symbols;
    logic [MAX_SYMBOLS-1:0][7:0] symbols;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_symbols_low  <= '0;
            r_symbols_high <= '0;
            r_base_length  <= BASE_LENGTH_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_SYMBOLS_LOW:  r_symbols_low  <= i_cfg_wdata;
                CFG_SYMBOLS_HIGH: r_symbols_high <= i_cfg_wdata;
                CFG_BASE_LENGTH:  r_base_length  <= i_cfg_wdata[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    assign all_symbols = {r_symbols_high, r_symbols_low};

    always_comb begin
        for (int k = 0; k < MAX_SYMBOLS; k++) begin
            symbols[k] = all_symbols[k*8 +: 8];
        end
    end

    assign used_len = (r_base_length > LEN_W'(MAX_SYMBOLS)) ? LEN_W'(MAX_SYMBOLS)
                                                            : r_base_length;

    always_comb begin
        logic bad;
        bad = (used_len < LEN_W'(2));
        for (int i = 0; i < MAX_SYMBOLS; i++) begin
            if (LEN_W'(i) < used_len) begin
                if (symbols[i] == CHAR_NUL || symbols[i] == CHAR_PLUS ||
                    symbols[i] == CHAR_MINUS || is_space(symbols[i])) begin
                    bad = 1'b1;
                end
                for (int j = i + 1; j < MAX_SYMBOLS; j++) begin
                    if ((LEN_W'(j) < used_len) && (symbols[j] == symbols[i])) begin
                        bad = 1'b1;
                    end
                end
            end
        end
        n_alphabet_ok = !bad;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alphabet_ok <= 1'b0;
        end else begin
            r_alphabet_ok <= n_alphabet_ok;
        end
    end

    assign o_cfg.symbols     = symbols;
    assign o_cfg.used_len    = used_len;
    assign o_cfg.alphabet_ok = r_alphabet_ok;

endmodule

@@ rtl/stoi_front.sv @@
// Front end: classifies each incoming character against the configured alphabet.
module stoi_front import stoi_pkg::*; (
    input  logic [7:0] i_character,
    input  logic       i_end_of_string,
    input  t_cfg_view  i_cfg,
    output t_class     o_class
);

    logic [MAX_SYMBOLS-1:0] hit;
    logic                   found;
    logic [SYM_IDX_W-1:0]   first_hit;

    always_comb begin
        for (int k = 0; k < MAX_SYMBOLS; k++) begin
            hit[k] = (LEN_W'(k) < i_cfg.used_len) && (i_cfg.symbols[k] == i_character);
        end
    end

    // The lowest matching symbol wins, so scan downwards and let later hits overwrite.
    always_comb begin
        found     = 1'b0;
        first_hit = '0;
        for (int k = MAX_SYMBOLS - 1; k >= 0; k--) begin
            if (hit[k]) begin
                found     = 1'b1;
                first_hit = SYM_IDX_W'(k);
            end
        end
    end

    assign o_class.last     = i_end_of_string;
    assign o_class.is_space = is_space(i_character);
    assign o_class.is_plus  = (i_character == CHAR_PLUS);
    assign o_class.is_minus = (i_character == CHAR_MINUS);
    assign o_class.is_digit = found && (i_character != CHAR_PLUS);
    assign o_class.digit    = first_hit;

endmodule

@@ rtl/stoi_cq.sv @@
// Short queue of classified characters between the front end and the back end.
module stoi_cq import stoi_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_class i_item,
    output logic   o_full,
    input  logic   i_pop,
    output t_class o_item,
    output logic   o_empty
);

    t_class              r_mem [CQ_DEPTH];
    logic [CQ_PTR_W-1:0] r_wr_ptr;
    logic [CQ_PTR_W-1:0] r_rd_ptr;
    logic [CQ_CNT_W-1:0] r_count;
    logic                do_push;
    logic                do_pop;

    assign o_full  = (r_count == CQ_CNT_W'(CQ_DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_item  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + CQ_PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + CQ_PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CQ_CNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CQ_CNT_W'(1);
            end
        end
    end

endmodule

@@ rtl/stoi_back.sv @@
// Back end: parsing state machine, digit accumulator and the result queue.
module stoi_back import stoi_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_cfg_view               i_cfg,
    input  t_class                  i_item,
    input  logic                    i_item_empty,
    output logic                    o_item_pop,
    input  logic                    i_pop,
    output logic                    o_empty,
    output logic signed [ACC_W-1:0] o_number,
    output logic                    o_alphabet_ok
);

    t_phase              r_phase;
    t_phase              n_phase;
    logic                r_minus_odd;
    logic                n_minus_odd;
    logic [ACC_W-1:0]    r_acc;
    logic [ACC_W-1:0]    n_acc;
    logic [ACC_W-1:0]    step_acc;
    logic                step_minus;
    logic [ACC_W+LEN_W-1:0] product;

    logic [ACC_W-1:0]    r_oq_acc   [OQ_DEPTH];
    logic                r_oq_minus [OQ_DEPTH];
    logic                r_oq_ok    [OQ_DEPTH];
    logic [OQ_PTR_W-1:0] r_oq_wr_ptr;
    logic [OQ_PTR_W-1:0] r_oq_rd_ptr;
    logic [OQ_CNT_W-1:0] r_oq_count;
    logic                oq_full;
    logic                oq_push;
    logic                oq_pop;
    logic [ACC_W-1:0]    head_acc;

    assign oq_full    = (r_oq_count == OQ_CNT_W'(OQ_DEPTH));
    assign o_item_pop = !i_item_empty && (!i_item.last || !oq_full);
    assign oq_push    = o_item_pop && i_item.last;
    assign oq_pop     = i_pop && !o_empty;

    assign product = {{LEN_W{1'b0}}, r_acc} * {{ACC_W{1'b0}}, i_cfg.used_len};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_SKIP;
            r_minus_odd <= 1'b0;
            r_acc       <= '0;
        end else begin
            r_phase     <= n_phase;
            r_minus_odd <= n_minus_odd;
            r_acc       <= n_acc;
        end
    end

    always_comb begin
        t_phase ph;
        ph         = r_phase;
        step_minus = r_minus_odd;
        step_acc   = r_acc;
        if (ph == PH_SKIP && !i_item.is_space) begin
            ph = PH_SIGNS;
        end
        if (ph == PH_SIGNS) begin
            if (i_item.is_minus) begin
                step_minus = !r_minus_odd;
            end else if (!i_item.is_plus) begin
                ph = PH_DIGITS;
            end
        end
        if (ph == PH_DIGITS) begin
            if (!i_item.is_digit) begin
                ph = PH_DONE;
            end else begin
                step_acc = product[ACC_W-1:0] + ACC_W'(i_item.digit);
            end
        end

        n_phase     = r_phase;
        n_minus_odd = r_minus_odd;
        n_acc       = r_acc;
        if (o_item_pop) begin
            if (i_item.last) begin
                n_phase     = PH_SKIP;
                n_minus_odd = 1'b0;
                n_acc       = '0;
            end else begin
                n_phase     = ph;
                n_minus_odd = step_minus;
                n_acc       = step_acc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (oq_push) begin
            r_oq_acc[r_oq_wr_ptr]   <= step_acc;
            r_oq_minus[r_oq_wr_ptr] <= step_minus;
            r_oq_ok[r_oq_wr_ptr]    <= i_cfg.alphabet_ok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oq_wr_ptr <= '0;
            r_oq_rd_ptr <= '0;
            r_oq_count  <= '0;
        end else begin
            if (oq_push) begin
                r_oq_wr_ptr <= r_oq_wr_ptr + OQ_PTR_W'(1);
            end
            if (oq_pop) begin
                r_oq_rd_ptr <= r_oq_rd_ptr + OQ_PTR_W'(1);
            end
            if (oq_push && !oq_pop) begin
                r_oq_count <= r_oq_count + OQ_CNT_W'(1);
            end else if (oq_pop && !oq_push) begin
                r_oq_count <= r_oq_count - OQ_CNT_W'(1);
            end
        end
    end

    assign o_empty       = (r_oq_count == '0);
    assign head_acc      = r_oq_acc[r_oq_rd_ptr];
    assign o_number      = r_oq_minus[r_oq_rd_ptr] ? signed'(ACC_W'(0) - head_acc)
                                                   : signed'(head_acc);
    assign o_alphabet_ok = r_oq_ok[r_oq_rd_ptr];

    a_oq_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_oq_count <= OQ_CNT_W'(OQ_DEPTH))
        else $error("Result queue holds more transactions than it has entries.");

    a_last_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_item_pop && i_item.last) |=> (r_phase == PH_SKIP && !r_minus_odd && r_acc == '0))
        else $error("Parser did not return to its idle state after the final character.");

    a_result_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (oq_push && !oq_pop) |=> (r_oq_count == $past(r_oq_count) + OQ_CNT_W'(1)))
        else $error("A finished string did not add a transaction to the result queue.");

    a_done_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_DONE && o_item_pop && !i_item.last) |=>
            (r_phase == PH_DONE && r_acc == $past(r_acc)))
        else $error("Characters after the end of the number changed the accumulator.");

endmodule

@@ rtl/string_to_int_custom_base.sv @@
// Top level of the string-to-integer converter with a configurable digit alphabet.
// A final character passes through the character queue, and its result through the result queue.
// Throughput: one character per cycle while neither queue is full; the back end does one multiply-add per digit.
// Results leave through a two-entry queue, so input continues while a result waits.
// Reset is synchronous and active low: it clears the parser, both queues and sets the
// alphabet to all zero bytes with a base length of ten.
module string_to_int_custom_base import stoi_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [SYM_REG_W-1:0]    i_cfg_wdata,
    input  logic                    push,
    output logic                    full,
    input  logic [7:0]              i_character,
    input  logic                    i_end_of_string,
    input  logic                    pop,
    output logic                    empty,
    output logic signed [ACC_W-1:0] o_number,
    output logic                    o_alphabet_ok
);

    t_cfg_view cfg;
    t_class    front_class;
    t_class    queued_class;
    logic      cq_empty;
    logic      cq_pop;

    stoi_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    stoi_front u_front (
        .i_character     (i_character),
        .i_end_of_string (i_end_of_string),
        .i_cfg           (cfg),
        .o_class         (front_class)
    );

    stoi_cq u_cq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (front_class),
        .o_full  (full),
        .i_pop   (cq_pop),
        .o_item  (queued_class),
        .o_empty (cq_empty)
    );

    stoi_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (cfg),
        .i_item        (queued_class),
        .i_item_empty  (cq_empty),
        .o_item_pop    (cq_pop),
        .i_pop         (pop),
        .o_empty       (empty),
        .o_number      (o_number),
        .o_alphabet_ok (o_alphabet_ok)
    );

endmodule

@@ tb/tb_top.sv @@
// Self-checking testbench for the custom-base string-to-integer converter, checked by a parser model.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import stoi_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int          ITEM_TARGET = 600;
    localparam int          IDLE_PCT    = 38;

    localparam logic [63:0] DEC_LO = 64'h3736353433323130;
    localparam logic [63:0] DEC_HI = 64'h0000000000003938;
    localparam logic [63:0] HEX_HI = 64'hFF45444342413938;

    typedef struct packed {
        logic signed [ACC_W-1:0] number;
        logic                    alphabet_ok;
    } t_result;

    typedef enum bit {ROW_CHAR, ROW_CONFIG} t_row_kind;

    typedef struct {
        t_row_kind   kind;
        logic [7:0]  chr;
        logic        last;
        bit          typed;
        t_result     want;
        logic [63:0] lo;
        logic [63:0] hi;
        logic [4:0]  len;
    } t_row;

    typedef enum int {
        ALPHA_UNIQUE,
        ALPHA_STANDARD,
        ALPHA_RANDOM,
        ALPHA_FAULTY,
        ALPHA_ALL_ONES
    } t_alphabet_kind;

    logic                    i_clk           = 1'b0;
    logic                    i_rst_n         = 1'b0;
    logic                    i_cfg_we        = 1'b0;
    logic [CFG_IDX_W-1:0]    i_cfg_index     = '0;
    logic [SYM_REG_W-1:0]    i_cfg_wdata     = '0;
    logic                    push            = 1'b0;
    logic                    full;
    logic [7:0]              i_character     = 8'h01;
    logic                    i_end_of_string = 1'b0;
    logic                    pop             = 1'b0;
    logic                    empty;
    logic signed [ACC_W-1:0] o_number;
    logic                    o_alphabet_ok;

    t_phase      parse_phase      = PH_SKIP;
    logic        minus_odd        = 1'b0;
    logic [31:0] accumulator      = '0;
    logic [63:0] cfg_symbols_low  = '0;
    logic [63:0] cfg_symbols_high = '0;
    logic [4:0]  cfg_base_length  = 5'd10;

    t_result     expected_numbers[$];
    int          mismatches  = 0;
    int          items_sent  = 0;
    int          idle_pct    = IDLE_PCT;
    int unsigned cycle_count = 0;

    t_row directed_table [27] = '{
        '{ROW_CHAR,   "7",        1, 1, '{0, 0},   0,      0,      0},
        '{ROW_CONFIG, 0,          0, 0, '{0, 0},   DEC_LO, DEC_HI, 10},
        '{ROW_CHAR,   CHAR_SPACE, 0, 0, '{0, 0},   0,      0,      0},
        '{ROW_CHAR,   CHAR_TAB,   0, 0, '{0, 0},   0,      0,      0},
        '{ROW_CHAR,   CHAR_CR,    0, 0, '{0, 0},   0,      0,      0},
        '{ROW_CHAR,   CHAR_PLUS,  0, 0, '{0, 0},   0,      0,      0},
        '{ROW_CHAR,   CHAR_MINUS, 0, 0, '{0, 0},   0,      0,      0},
        '{ROW_CHAR,   "4",        0, 0, '{0, 0},   0,      0,      0},
        '{ROW_CHAR,   "2",        1, 1, '{-42, 1}, 0,      0,      0},
        '{ROW_CHAR,   "5",        0, 0, '{0, 0},   0,      0,      0},
        '{ROW_CHAR,   "x",        1, 1, '{5, 1},   0,      0,      0},
        '{ROW_CHAR,   8'hFF,      1, 1, '{0, 1},   0,      0,      0},
        '{ROW_CHAR,   CHAR_MINUS, 0, 0, '{0, 0},   0,      0,      0},
        '{ROW_CHAR,   CHAR_MINUS, 0, 0, '{0, 0},   0,      0,      0},
        '{ROW_CHAR,   "7",        0, 0, '{0, 0},   0,      0,      0},
        '{ROW_CHAR,   CHAR_PLUS,  0, 0, '{0, 0},   0,      0,      0},
        '{ROW_CHAR,   "1",        1, 1, '{7, 1},   0,      0,      0},
        '{ROW_CONFIG, 0,          0, 0, '{0, 0},   DEC_LO, HEX_HI, 31},
        '{ROW_CHAR,   8'hFF,      0, 0, '{0, 0},   0,      0,      0},
        '{ROW_CHAR,   8'hFF,      0, 0, '{0, 0},   0,      0,      0},
        '{ROW_CHAR,   8'hFF,      0, 0, '{0, 0},   0,      0,      0},
        '{ROW_CHAR,   8'hFF,      0, 0, '{0, 0},   0,      0,      0},
        '{ROW_CHAR,   8'hFF,      0, 0, '{0, 0},   0,      0,      0},
        '{ROW_CHAR,   8'hFF,      0, 0, '{0, 0},   0,      0,      0},
        '{ROW_CHAR,   8'hFF,      0, 0, '{0, 0},   0,      0,      0},
        '{ROW_CHAR,   8'hFF,      0, 0, '{0, 0},   0,      0,      0},
        '{ROW_CHAR,   8'hFF,      1, 1, '{-1, 1},  0,      0,      0}
    };

    string_to_int_custom_base u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_wdata     (i_cfg_wdata),
        .push            (push),
        .full            (full),
        .i_character     (i_character),
        .i_end_of_string (i_end_of_string),
        .pop             (pop),
        .empty           (empty),
        .o_number        (o_number),
        .o_alphabet_ok   (o_alphabet_ok)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    function automatic bit blank_char(input logic [7:0] c);
        return (c == CHAR_SPACE) || ((c >= CHAR_TAB) && (c <= CHAR_CR));
    endfunction

    function automatic int used_len();
        return (cfg_base_length > 5'd16) ? 16 : int'(cfg_base_length);
    endfunction

    function automatic int symbol_index(input logic [7:0] c, input int n);
        logic [15:0][7:0] syms;
        syms = {cfg_symbols_high, cfg_symbols_low};
        for (int k = 0; k < n; k++) begin
            if (syms[k] == c) return k;
        end
        return -1;
    endfunction

    function automatic logic alphabet_is_valid(input int n);
        logic [15:0][7:0] syms;
        logic [7:0]       s;
        syms = {cfg_symbols_high, cfg_symbols_low};
        if (n < 2) return 1'b0;
        for (int i = 0; i < n; i++) begin
            s = syms[i];
            if (s == CHAR_NUL || s == CHAR_PLUS || s == CHAR_MINUS || blank_char(s)) return 1'b0;
            for (int j = i + 1; j < n; j++) begin
                if (syms[j] == s) return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    function automatic bit advance_parser(input logic [7:0] c, input logic last,
                                          output t_result res);
        int idx;
        int n;
        n   = used_len();
        res = '0;
        if (parse_phase == PH_SKIP && !blank_char(c)) parse_phase = PH_SIGNS;
        if (parse_phase == PH_SIGNS) begin
            if (c == CHAR_MINUS) begin
                minus_odd = ~minus_odd;
            end else if (c != CHAR_PLUS) begin
                parse_phase = PH_DIGITS;
            end
        end
        if (parse_phase == PH_DIGITS) begin
            idx = (c == CHAR_PLUS) ? -1 : symbol_index(c, n);
            if (idx < 0) begin
                parse_phase = PH_DONE;
            end else begin
                accumulator = accumulator * 32'(n) + 32'(idx);
            end
        end
        if (!last) return 1'b0;
        res.number      = minus_odd ? -accumulator : accumulator;
        res.alphabet_ok = alphabet_is_valid(n);
        parse_phase     = PH_SKIP;
        minus_odd       = 1'b0;
        accumulator     = '0;
        return 1'b1;
    endfunction

    function automatic logic [7:0] pick_digit();
        logic [15:0][7:0] syms;
        logic [7:0]       c;
        int               n;
        syms = {cfg_symbols_high, cfg_symbols_low};
        n    = used_len();
        if (n == 0) return 8'($urandom_range(1, 255));
        c = syms[$urandom_range(n - 1)];
        return (c == CHAR_NUL) ? 8'h01 : c;
    endfunction

    task automatic report_mismatch(input string what);
        mismatches++;
        if (mismatches <= 50) $display("[%0t] mismatch: %s", $time, what);
    endtask

    task automatic send_item(input logic [7:0] c, input logic last, input bit typed,
                             input t_result want);
        t_result res;
        idle_pct = (items_sent >= 250 && items_sent < 350) ? 0 : IDLE_PCT;
        while ($urandom_range(99) < idle_pct) begin
            push <= 1'b0;
            @(negedge i_clk);
        end
        push            <= 1'b1;
        i_character     <= c;
        i_end_of_string <= last;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        if (advance_parser(c, last, res)) expected_numbers.push_back(typed ? want : res);
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic wait_idle();
        push <= 1'b0;
        while (expected_numbers.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic program_alphabet(input logic [63:0] lo, input logic [63:0] hi,
                                    input logic [63:0] len_word);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_SYMBOLS_LOW;
        i_cfg_wdata <= lo;
        @(negedge i_clk);
        i_cfg_index <= CFG_SYMBOLS_HIGH;
        i_cfg_wdata <= hi;
        @(negedge i_clk);
        i_cfg_index <= CFG_BASE_LENGTH;
        i_cfg_wdata <= len_word;
        @(negedge i_clk);
        i_cfg_we         <= 1'b0;
        cfg_symbols_low  = lo;
        cfg_symbols_high = hi;
        cfg_base_length  = len_word[4:0];
    endtask

    task automatic program_random_alphabet();
        logic [15:0][7:0] syms;
        logic [63:0]      len_word;
        bit [255:0]       taken;
        logic [7:0]       c;
        t_alphabet_kind   kind;
        int               n;
        int               pos;
        len_word = {$urandom, $urandom};
        case ($urandom_range(9))
            0:       len_word[4:0] = 5'd0;
            1:       len_word[4:0] = 5'd1;
            2:       len_word[4:0] = 5'd2;
            3:       len_word[4:0] = 5'd16;
            4:       len_word[4:0] = 5'd31;
            5:       len_word[4:0] = 5'($urandom_range(17, 31));
            default: len_word[4:0] = 5'($urandom_range(2, 16));
        endcase
        n     = (len_word[4:0] > 5'd16) ? 16 : int'(len_word[4:0]);
        kind  = t_alphabet_kind'($urandom_range(4));
        taken = '0;
        syms  = '0;
        case (kind)
            ALPHA_STANDARD: begin
                for (int k = 0; k < 16; k++) syms[k] = (k < 10) ? 8'(8'h30 + k) : 8'(8'h37 + k);
            end
            ALPHA_RANDOM:   syms = {$urandom, $urandom, $urandom, $urandom};
            ALPHA_ALL_ONES: syms = '1;
            default: begin
                for (int k = 0; k < 16; k++) begin
                    do begin
                        c = 8'($urandom_range(1, 255));
                    end while (blank_char(c) || c == CHAR_PLUS || c == CHAR_MINUS || taken[c]);
                    taken[c] = 1'b1;
                    syms[k]  = c;
                end
            end
        endcase
        if (kind == ALPHA_FAULTY) begin
            pos = (n > 1) ? $urandom_range(n - 1) : 0;
            case ($urandom_range(4))
                0:       syms[pos] = CHAR_NUL;
                1:       syms[pos] = CHAR_PLUS;
                2:       syms[pos] = CHAR_MINUS;
                3:       syms[pos] = $urandom_range(1) ? CHAR_SPACE
                                                       : 8'($urandom_range(CHAR_TAB, CHAR_CR));
                default: syms[pos] = syms[pos ^ 1];
            endcase
        end
        program_alphabet(syms[7:0], syms[15:8], len_word);
    endtask

    task automatic send_random_string();
        logic [7:0] text[$];
        int         n_digits;
        if ($urandom_range(99) < 85) begin
            repeat ($urandom_range(0, 2)) begin
                text.push_back($urandom_range(1) ? CHAR_SPACE
                                                 : 8'($urandom_range(CHAR_TAB, CHAR_CR)));
            end
            repeat ($urandom_range(0, 3)) text.push_back($urandom_range(1) ? CHAR_PLUS : CHAR_MINUS);
            n_digits = ($urandom_range(9) == 0) ? $urandom_range(9, 14) : $urandom_range(1, 8);
            repeat (n_digits) text.push_back(pick_digit());
            if ($urandom_range(3) == 0) begin
                repeat ($urandom_range(1, 3)) text.push_back(8'($urandom_range(1, 255)));
            end
        end else begin
            repeat ($urandom_range(1, 6)) text.push_back(8'($urandom_range(1, 255)));
        end
        foreach (text[i]) send_item(text[i], i == text.size() - 1, 1'b0, '0);
    endtask

    always @(negedge i_clk) begin
        pop <= i_rst_n && ($urandom_range(99) >= idle_pct);
    end

    always @(posedge i_clk) begin : result_check
        t_result want;
        if (i_rst_n && pop && !empty) begin
            if (expected_numbers.size() == 0) begin
                report_mismatch($sformatf("result %0d with no transaction pending", o_number));
            end else begin
                want = expected_numbers.pop_front();
                if (o_number !== want.number) begin
                    report_mismatch($sformatf("number %0d, expected %0d", o_number, want.number));
                end
                if (o_alphabet_ok !== want.alphabet_ok) begin
                    report_mismatch($sformatf("alphabet_ok %b, expected %b",
                                              o_alphabet_ok, want.alphabet_ok));
                end
            end
        end
    end

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("tb_top failed");
        $finish;
    end

    initial begin
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        foreach (directed_table[r]) begin
            if (directed_table[r].kind == ROW_CONFIG) begin
                wait_idle();
                program_alphabet(directed_table[r].lo, directed_table[r].hi,
                                 64'(directed_table[r].len));
            end else begin
                send_item(directed_table[r].chr, directed_table[r].last,
                          directed_table[r].typed, directed_table[r].want);
            end
        end
        while (items_sent < ITEM_TARGET) begin
            wait_idle();
            program_random_alphabet();
            repeat ($urandom_range(6, 14)) send_random_string();
        end
        wait_idle();
        repeat (6) @(negedge i_clk);
        if (mismatches == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

endmodule
